// ===== design/grwh_pkg.sv =====
// Package for the gyro rate window heading core.
// Holds widths, register indexes, reset values and divider types; no dependencies.
`default_nettype none
package grwh_pkg;
    localparam int unsigned DEPTH = 256;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = AW + 1;

    localparam logic [2:0] REG_RATE_SCALE   = 3'd0;
    localparam logic [2:0] REG_RATE_BIAS    = 3'd1;
    localparam logic [2:0] REG_DEAD_BAND    = 3'd2;
    localparam logic [2:0] REG_WINDOW_US    = 3'd3;
    localparam logic [2:0] REG_INTEGRATE_US = 3'd4;

    localparam logic [15:0] RST_RATE_SCALE   = 16'd1147;
    localparam logic [23:0] RST_RATE_BIAS    = 24'd29491;
    localparam logic [23:0] RST_DEAD_BAND    = 24'd65536;
    localparam logic [23:0] RST_WINDOW_US    = 24'd1000000;
    localparam logic [23:0] RST_INTEGRATE_US = 24'd1000000;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    // Start and result of the shared signed divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [24:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== design/grwh_div.sv =====
// Signed truncating divider, one quotient bit per cycle.
// Depends on grwh_pkg.
`default_nettype none
module grwh_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  grwh_pkg::t_div_req i_req,
    output grwh_pkg::t_div_rsp o_rsp
);
    logic        r_busy, r_neg, r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [25:0] r_rem;
    logic [24:0] r_den;
    logic [25:0] n_trial;
    logic [25:0] n_shift;

    assign n_shift = {r_rem[24:0], r_q[63]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_neg  <= i_req.dividend[63];
                r_q    <= i_req.dividend[63] ? -i_req.dividend : i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!n_trial[25]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -r_q : r_q;
endmodule
`default_nettype wire

// ===== design/gyro_rate_window_heading_core.sv =====
// Top level of the gyro rate window heading core: ring memories, sequencer
// and output register. Depends on grwh_pkg and grwh_div.
//
//  channel    | dir | payload
//  s_axis     | in  | tdata: raw_rate[15:0], interval_us[39:16]
//  m_axis     | out | tdata: mean_rate[31:0], heading[79:32], window_count[88:80]
//  cfg        | in  | index[2:0], data[23:0]
//
// Each word passes S_RATE, S_WAIT, S_CHECK, S_APPEND and S_MEAN, then waits in
// S_MWAIT on the bit-serial divider for the mean. Each dropped entry adds S_AGE,
// S_WAIT and S_CHECK; a heading update adds S_HEAD and S_HWAIT for its division.
// Reset is synchronous; the ring memories are not cleared, entries beyond the
// count are never used. A new word is taken only once the previous result has
// moved into the output register; the output register holds while m_axis_tready
// is low, and the sequencer waits in S_OUT while it is full and m_axis_tready is low.
`default_nettype none
module gyro_rate_window_heading_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // raw_rate, interval_us
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // mean_rate, heading, window_count, zero fill
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    localparam int unsigned AW = grwh_pkg::AW;
    localparam int unsigned CW = grwh_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_CHECK, S_WAIT, S_AGE, S_APPEND, S_MEAN, S_MWAIT,
        S_HEAD, S_HWAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_scale;
    logic signed [23:0] r_bias;
    logic [23:0] r_dband, r_win, r_integ;

    logic [31:0] r_rate_mem [grwh_pkg::DEPTH];
    logic [31:0] r_stamp_mem [grwh_pkg::DEPTH];
    logic [31:0] r_rd_rate, r_rd_stamp;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic signed [41:0] r_sum;
    logic [31:0] r_time, r_prev;
    logic [24:0] r_since;
    logic [47:0] r_heading;
    logic signed [15:0] r_raw;
    logic [23:0] r_dt;
    logic signed [32:0] r_prod;
    logic signed [31:0] r_rate, r_mean;
    logic signed [52:0] r_mprod;
    logic r_ovalid;
    logic [88:0] r_odata;

    grwh_pkg::t_div_req n_req;
    grwh_pkg::t_div_rsp w_rsp;

    grwh_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_req), .o_rsp(w_rsp));

    logic signed [33:0] n_biased;
    logic signed [31:0] n_sat, n_mag_rate;
    logic [32:0] n_mag;
    logic [AW-1:0] n_tail;
    logic [31:0] n_age;
    logic [CW-1:0] n_cnt1;

    always_comb begin
        n_biased = {r_prod[32], r_prod} + 34'(r_bias);
        if (n_biased > 34'sd2147483647)       n_sat = 32'sh7fffffff;
        else if (n_biased < -34'sd2147483648) n_sat = 32'sh80000000;
        else                                  n_sat = n_biased[31:0];
        n_mag = n_sat[31] ? 33'(-{n_sat[31], n_sat}) : {1'b0, n_sat};
        n_mag_rate = (n_mag < {9'd0, r_dband}) ? 32'sd0 : n_sat;
        n_tail = r_head + r_count[AW-1:0];
        n_age  = r_time - r_rd_stamp;
        n_cnt1 = r_count + CW'(1);
    end

    always_comb begin
        n_req.start    = 1'b0;
        n_req.dividend = 64'(r_sum);
        n_req.divisor  = 25'(r_count);
        if (r_state == S_MEAN) n_req.start = 1'b1;
        if (r_state == S_HEAD) begin
            n_req.start    = 1'b1;
            n_req.dividend = 64'(r_mprod);
            n_req.divisor  = r_since;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_odata};

    always_ff @(posedge i_clk) begin
        r_rd_rate  <= r_rate_mem[r_head];
        r_rd_stamp <= r_stamp_mem[r_head];
        if (r_state == S_APPEND) begin
            r_rate_mem[n_tail]  <= r_rate;
            r_stamp_mem[n_tail] <= r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scale   <= grwh_pkg::RST_RATE_SCALE;
            r_bias    <= grwh_pkg::RST_RATE_BIAS;
            r_dband   <= grwh_pkg::RST_DEAD_BAND;
            r_win     <= grwh_pkg::RST_WINDOW_US;
            r_integ   <= grwh_pkg::RST_INTEGRATE_US;
            r_head    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_time    <= '0;
            r_since   <= '0;
            r_heading <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    grwh_pkg::REG_RATE_SCALE:   r_scale <= i_cfg_data[15:0];
                    grwh_pkg::REG_RATE_BIAS:    r_bias  <= i_cfg_data;
                    grwh_pkg::REG_DEAD_BAND:    r_dband <= i_cfg_data;
                    grwh_pkg::REG_WINDOW_US:    r_win   <= i_cfg_data;
                    grwh_pkg::REG_INTEGRATE_US: r_integ <= i_cfg_data;
                    default: ;
                endcase
            end
            // S_OUT refills the output register itself.
            if (r_ovalid && m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_raw   <= s_axis_tdata[15:0];
                    r_dt    <= s_axis_tdata[39:16];
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_prod  <= r_raw * $signed({1'b0, r_scale});
                    r_prev  <= r_time;
                    r_time  <= r_time + 32'(r_dt);
                    r_since <= r_since + 25'(r_dt);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // Memory read of the head entry lands next cycle.
                    r_rate  <= n_mag_rate;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_count != '0 && n_age > 32'(r_win)) r_state <= S_AGE;
                    else if (r_count >= CW'(grwh_pkg::DEPTH)) r_state <= S_AGE;
                    else r_state <= S_APPEND;
                end
                S_AGE: begin
                    r_sum   <= r_sum - 42'($signed(r_rd_rate));
                    r_head  <= r_head + AW'(1);
                    r_count <= r_count - CW'(1);
                    r_state <= S_WAIT;
                end
                S_APPEND: begin
                    r_count <= n_cnt1;
                    r_sum   <= r_sum + 42'(r_rate);
                    r_state <= S_MEAN;
                end
                S_MEAN: r_state <= S_MWAIT;
                S_MWAIT: if (w_rsp.done) begin
                    r_mean  <= w_rsp.quotient[31:0];
                    r_mprod <= $signed(w_rsp.quotient[31:0]) * $signed({1'b0, grwh_pkg::US_PER_S});
                    r_state <= (r_since > {1'b0, r_integ}) ? S_HEAD : S_OUT;
                end
                S_HEAD: r_state <= S_HWAIT;
                S_HWAIT: if (w_rsp.done) begin
                    r_heading <= r_heading + w_rsp.quotient[47:0];
                    r_since   <= '0;
                    r_state   <= S_OUT;
                end
                S_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_odata  <= {9'(r_count), r_heading, r_mean};
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(grwh_pkg::DEPTH)) else $error("ring count overflow");
    a_append_nonfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPEND |-> r_count < CW'(grwh_pkg::DEPTH)) else $error("append to full ring");
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_count != '0) else $error("empty window at output");
endmodule
`default_nettype wire
